@@ hdl/hhs_pkg.sv @@
// ----------------------------------------------------------------------------
// hhs_pkg
// Shared types, sizes and the sort key compare for the diagonal hit sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package hhs_pkg;

    localparam int MAX_HITS = 64;
    localparam int IDXW     = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int CNTW     = $clog2(MAX_HITS + 1);
    localparam int CW       = CNTW + 1;

    typedef struct packed {
        logic [19:0] query_pos;
        logic [31:0] genome_pos;
        logic [31:0] diagonal;
        logic        last_hit;
    } t_hit_in;

    typedef struct packed {
        logic [19:0] out_query_pos;
        logic [31:0] out_genome_pos;
        logic [31:0] out_diagonal;
        logic        end_of_group;
        logic        overflowed;
    } t_hit_out;

    // One stored hit.
    typedef struct packed {
        logic [31:0] diagonal;
        logic [19:0] query_pos;
        logic [31:0] genome_pos;
    } t_entry;

    // A classified item on its way from the front to the back.
    typedef struct packed {
        t_entry          hit;
        logic [IDXW-1:0] addr;
        logic            keep;
        logic            last;
        logic [CNTW-1:0] count;
    } t_qitem;

    // Front-to-back queue handshake.
    typedef struct packed {
        logic   valid;
        t_qitem item;
    } t_queue;

    // True when a orders strictly before b.
    function automatic logic key_less(input t_entry a, input t_entry b);
        return {a.diagonal, a.query_pos} < {b.diagonal, b.query_pos};
    endfunction

endpackage

`default_nettype wire

@@ hdl/hhs_in_if.sv @@
// ----------------------------------------------------------------------------
// hhs_in_if
// Input channel: valid/ready handshake carrying one seed hit.
// ----------------------------------------------------------------------------
`default_nettype none

interface hhs_in_if;
    logic             valid;
    logic             ready;
    hhs_pkg::t_hit_in payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/hhs_out_if.sv @@
// ----------------------------------------------------------------------------
// hhs_out_if
// Output channel: valid/ready handshake carrying one sorted hit.
// ----------------------------------------------------------------------------
`default_nettype none

interface hhs_out_if;
    logic              valid;
    logic              ready;
    hhs_pkg::t_hit_out payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/hit_heap_sort_by_diagonal_core.sv @@
// Loading: one hit per cycle in S_LOAD; when the back is busy the front queue fills, then stalls.
// Sorting after the closing hit: heapsort in memory, with n/2 build sift-downs, then
// n-1 extraction sift-downs that each move the root out and sift the old last element down.
// Emission: each hit is read from memory, then loaded into the output register once it is free.
// A new group is loaded only once the previous group's last hit is in the output register.
// Synchronous active-low reset clears counters, queue and control; the hit memory is not cleared.
// ----------------------------------------------------------------------------
// hit_heap_sort_by_diagonal_core
// Top level: front classifier and queue feeding the heapsort and emit engine.
// ----------------------------------------------------------------------------
`default_nettype none

module hit_heap_sort_by_diagonal_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hhs_in_if.sink    i_in,
    hhs_out_if.source o_out
);

    hhs_pkg::t_queue w_queue;
    logic            w_pop;

    hhs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_queue (w_queue),
        .i_pop   (w_pop)
    );

    hhs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_queue (w_queue),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

@@ hdl/hhs_front.sv @@
// ----------------------------------------------------------------------------
// hhs_front
// Accepts hits, assigns each a store slot or marks it dropped, and queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module hhs_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    hhs_in_if.sink               i_in,
    output hhs_pkg::t_queue      o_queue,
    input  wire logic            i_pop
);

    logic [hhs_pkg::CNTW-1:0] r_count;
    hhs_pkg::t_qitem          r_q [2];
    logic                     r_wp;
    logic                     r_rp;
    logic [1:0]               r_fill;

    logic            w_push;
    logic            w_pop;
    logic            w_keep;
    hhs_pkg::t_qitem w_item;

    assign i_in.ready = (r_fill != 2'd2);
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = i_pop && (r_fill != 2'd0);
    assign w_keep     = (r_count < hhs_pkg::CNTW'(hhs_pkg::MAX_HITS));

    always_comb begin
        w_item.hit.diagonal   = i_in.payload.diagonal;
        w_item.hit.query_pos  = i_in.payload.query_pos;
        w_item.hit.genome_pos = i_in.payload.genome_pos;
        w_item.addr           = r_count[hhs_pkg::IDXW-1:0];
        w_item.keep           = w_keep;
        w_item.last           = i_in.payload.last_hit;
        w_item.count          = w_keep ? r_count + hhs_pkg::CNTW'(1) : r_count;
    end

    assign o_queue.valid = (r_fill != 2'd0);
    assign o_queue.item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_fill  <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_item;
                r_wp      <= ~r_wp;
                // The closing hit starts the next group at slot zero.
                r_count   <= w_item.last ? '0 : w_item.count;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_fill <= r_fill + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

`default_nettype wire

@@ hdl/hhs_back.sv @@
// ----------------------------------------------------------------------------
// hhs_back
// Stores queued hits, heapsorts the closed group in memory, emits it in order.
// ----------------------------------------------------------------------------
`default_nettype none

module hhs_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire hhs_pkg::t_queue i_queue,
    output logic                 o_pop,
    hhs_out_if.source            o_out
);

    typedef enum logic [3:0] {
        S_LOAD, S_BLD, S_BLD_RD, S_SIFT, S_CMP, S_NEXT,
        S_SWAP, S_SWAP_RD, S_EMIT_RD, S_EMIT_LD
    } t_state;

    t_state                   r_state;
    hhs_pkg::t_entry          r_mem [hhs_pkg::MAX_HITS];
    hhs_pkg::t_entry          r_rd_a;
    hhs_pkg::t_entry          r_rd_b;
    hhs_pkg::t_entry          r_cur;
    logic [hhs_pkg::CNTW-1:0] r_n;
    logic [hhs_pkg::CNTW-1:0] r_i;
    logic [hhs_pkg::CNTW-1:0] r_size;
    logic [hhs_pkg::CNTW-1:0] r_k;
    logic [hhs_pkg::IDXW-1:0] r_top;
    logic                     r_build;
    logic                     r_drop;
    logic                     r_ov;
    hhs_pkg::t_hit_out        r_out;

    logic                     w_we;
    logic [hhs_pkg::IDXW-1:0] w_waddr;
    hhs_pkg::t_entry          w_wdata;
    logic [hhs_pkg::IDXW-1:0] w_raddr_a;
    logic [hhs_pkg::IDXW-1:0] w_raddr_b;
    logic [hhs_pkg::CW-1:0]   w_c;
    logic [hhs_pkg::CW-1:0]   w_c1;
    logic                     w_leaf;
    logic                     w_pick_b;
    logic                     w_go;
    hhs_pkg::t_entry          w_child;
    logic [hhs_pkg::IDXW-1:0] w_cidx;
    logic                     w_emit_ok;
    logic                     w_emit_last;
    logic                     w_load_out;

    assign o_pop       = (r_state == S_LOAD);
    assign o_out.valid = r_ov;
    assign o_out.payload = r_out;

    // Children of the current sift position.
    assign w_c    = hhs_pkg::CW'({r_top, 1'b1});
    assign w_c1   = w_c + hhs_pkg::CW'(1);
    assign w_leaf = (w_c >= hhs_pkg::CW'(r_size));

    // The three compares run side by side; selection follows.
    always_comb begin
        w_pick_b = (w_c1 < hhs_pkg::CW'(r_size)) && hhs_pkg::key_less(r_rd_a, r_rd_b);
        w_go     = w_pick_b ? hhs_pkg::key_less(r_cur, r_rd_b)
                            : hhs_pkg::key_less(r_cur, r_rd_a);
        w_child  = w_pick_b ? r_rd_b : r_rd_a;
        w_cidx   = w_pick_b ? w_c1[hhs_pkg::IDXW-1:0] : w_c[hhs_pkg::IDXW-1:0];
    end

    assign w_emit_ok   = !r_ov || o_out.ready;
    assign w_emit_last = (r_k + hhs_pkg::CNTW'(1) == r_n);
    assign w_load_out  = (r_state == S_EMIT_LD) && w_emit_ok;

    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_top;
        w_wdata   = r_cur;
        w_raddr_a = r_k[hhs_pkg::IDXW-1:0];
        w_raddr_b = w_c1[hhs_pkg::IDXW-1:0];
        case (r_state)
            S_LOAD: begin
                w_we    = i_queue.valid && i_queue.item.keep;
                w_waddr = i_queue.item.addr;
                w_wdata = i_queue.item.hit;
            end
            S_BLD: begin
                w_raddr_a = hhs_pkg::IDXW'(r_i - hhs_pkg::CNTW'(1));
            end
            S_SIFT: begin
                w_we      = w_leaf;
                w_raddr_a = w_c[hhs_pkg::IDXW-1:0];
            end
            S_CMP: begin
                w_we    = 1'b1;
                w_wdata = w_go ? w_child : r_cur;
            end
            S_SWAP: begin
                w_raddr_a = '0;
                w_raddr_b = r_i[hhs_pkg::IDXW-1:0];
            end
            S_SWAP_RD: begin
                w_we    = 1'b1;
                w_waddr = r_i[hhs_pkg::IDXW-1:0];
                w_wdata = r_rd_a;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_a <= r_mem[w_raddr_a];
        r_rd_b <= r_mem[w_raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_build <= 1'b0;
            r_drop  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (i_queue.valid) begin
                        r_drop <= r_drop | !i_queue.item.keep;
                        if (i_queue.item.last) begin
                            r_n    <= i_queue.item.count;
                            r_size <= i_queue.item.count;
                            r_i    <= i_queue.item.count >> 1;
                            r_k    <= '0;
                            if (i_queue.item.count < hhs_pkg::CNTW'(2)) begin
                                r_state <= S_EMIT_RD;
                            end else begin
                                r_build <= 1'b1;
                                r_state <= S_BLD;
                            end
                        end
                    end
                end
                S_BLD: begin
                    r_state <= S_BLD_RD;
                end
                S_BLD_RD: begin
                    r_cur   <= r_rd_a;
                    r_top   <= hhs_pkg::IDXW'(r_i - hhs_pkg::CNTW'(1));
                    r_state <= S_SIFT;
                end
                S_SIFT: begin
                    r_state <= w_leaf ? S_NEXT : S_CMP;
                end
                S_CMP: begin
                    if (w_go) begin
                        r_top   <= w_cidx;
                        r_state <= S_SIFT;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_i == hhs_pkg::CNTW'(1)) begin
                        if (r_build) begin
                            r_build <= 1'b0;
                            r_i     <= r_n - hhs_pkg::CNTW'(1);
                            r_state <= S_SWAP;
                        end else begin
                            r_k     <= '0;
                            r_state <= S_EMIT_RD;
                        end
                    end else begin
                        r_i     <= r_i - hhs_pkg::CNTW'(1);
                        r_state <= r_build ? S_BLD : S_SWAP;
                    end
                end
                S_SWAP: begin
                    r_state <= S_SWAP_RD;
                end
                S_SWAP_RD: begin
                    // The old last element becomes the sift value at the root.
                    r_cur   <= r_rd_b;
                    r_top   <= '0;
                    r_size  <= r_i;
                    r_state <= S_SIFT;
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    if (w_emit_ok) begin
                        r_out.out_query_pos  <= r_rd_a.query_pos;
                        r_out.out_genome_pos <= r_rd_a.genome_pos;
                        r_out.out_diagonal   <= r_rd_a.diagonal;
                        r_out.end_of_group   <= w_emit_last;
                        r_out.overflowed     <= r_drop;
                        if (w_emit_last) begin
                            r_drop  <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_k     <= r_k + hhs_pkg::CNTW'(1);
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
